// File: rtl/vicc_pkg.sv
// Package: shared types, constants and register indexes for the voxel index converter.
`timescale 1ns / 1ps
package vicc_pkg;

    localparam int DIM_MAX_DEF = 1024;
    localparam int DIM_W       = 11;
    localparam int COORD_W     = 10;
    localparam int HANDLE_W    = 31;
    localparam int STRIDE_W    = 22;
    localparam int VALUE_W     = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

    localparam logic [31:0] HASH_PX = 32'd73856093;
    localparam logic [31:0] HASH_PY = 32'd19349663;
    localparam logic [31:0] HASH_PZ = 32'd83492791;
    localparam logic [31:0] HASH_M1 = 32'h7feb352d;
    localparam logic [31:0] HASH_M2 = 32'h846ca68b;

    typedef struct packed {
        logic                func;
        logic [COORD_W-1:0]  coord_x;
        logic [COORD_W-1:0]  coord_y;
        logic [COORD_W-1:0]  coord_z;
        logic [HANDLE_W-1:0] handle_in;
    } in_t;

    typedef struct packed {
        logic                valid_res;
        logic [HANDLE_W-1:0] handle_out;
        logic [COORD_W-1:0]  x_out;
        logic [COORD_W-1:0]  y_out;
        logic [COORD_W-1:0]  z_out;
        logic [VALUE_W-1:0]  cell_value;
    } out_t;

    // State carried along the divider chain
    typedef struct packed {
        logic                func;
        logic                ok;
        logic [HANDLE_W-1:0] handle;
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [COORD_W-1:0]  cz;
        logic [DIM_W-1:0]    dx;
        logic [HANDLE_W-1:0] rem;
        logic [STRIDE_W-1:0] dvs;
        logic [COORD_W-1:0]  quo;
        logic [COORD_W-1:0]  zq;
    } pipe_t;

endpackage

// File: rtl/vicc_div_cell.sv
// Module: one restoring-division cell, resolves one quotient bit per stage.
`timescale 1ns / 1ps
module vicc_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vld_in,
    input  vicc_pkg::pipe_t d_in,
    output logic           vld_out,
    output vicc_pkg::pipe_t d_out
);
    import vicc_pkg::*;

    logic        vld_reg;
    pipe_t       d_reg;
    pipe_t       d_next;
    logic [32:0] sh;
    logic [32:0] diff;

    // Trial subtract of the shifted divisor
    always_comb
    begin
        sh     = 33'(d_in.dvs) << SHIFT;
        diff   = {2'b00, d_in.rem} - sh;
        d_next = d_in;
        if (!diff[32])
        begin
            d_next.rem = diff[HANDLE_W-1:0];
            d_next.quo = {d_in.quo[COORD_W-2:0], 1'b1};
        end
        else
        begin
            d_next.quo = {d_in.quo[COORD_W-2:0], 1'b0};
        end
    end

    // Advance valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vld_out = vld_reg;
    assign d_out   = d_reg;
endmodule

// File: rtl/vicc_hash.sv
// Module: pipelined spatial hash and output register for the cell value.
`timescale 1ns / 1ps
module vicc_hash (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_in,
    input  vicc_pkg::out_t res_in,
    output logic          vld_out,
    output vicc_pkg::out_t res_out
);
    import vicc_pkg::*;

    logic [3:0]  vld_reg;
    out_t        r1_reg, r2_reg, r3_reg, r4_reg;
    out_t        r4_next;
    logic [31:0] h1_reg, h2_reg, h3_reg;
    logic [31:0] h1_next, h2_next, h3_next, h4;

    // Compute hash steps between registers
    always_comb
    begin
        h1_next = (32'(res_in.x_out) * HASH_PX) ^ (32'(res_in.y_out) * HASH_PY)
                ^ (32'(res_in.z_out) * HASH_PZ);
        h2_next = (h1_reg ^ (h1_reg >> 16)) * HASH_M1;
        h3_next = (h2_reg ^ (h2_reg >> 15)) * HASH_M2;
        h4      = h3_reg ^ (h3_reg >> 16);
        r4_next = r3_reg;
        r4_next.cell_value = r3_reg.valid_res ?
            VALUE_W'(3'd1 + {1'b0, h4[1:0]}) : '0;
    end

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[2:0], vld_in};
    end

    // Advance payload and hash state
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg <= res_in;
            h1_reg <= h1_next;
            r2_reg <= r1_reg;
            h2_reg <= h2_next;
            r3_reg <= r2_reg;
            h3_reg <= h3_next;
            r4_reg <= r4_next;
        end
    end

    assign vld_out = vld_reg[3];
    assign res_out = r4_reg;
endmodule

// File: rtl/voxel_index_coordinate_convert_core.sv
// Module: top level of the voxel index to coordinate converter.
//
//  channel | signals                        | transaction when
//  --------+--------------------------------+---------------------------
//  in      | in_valid, in_stall, in_data    | in_valid && !in_stall
//  out     | out_valid, out_stall, out_data | out_valid && !out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// One transaction per cycle in, one per cycle out, while the output is not stalled.
// The path runs through four front stages, the two divider cell chains, one
// hand-off register behind each chain and four hash stages.
// Reset clears the dimension registers to 1 and all stage valid flags.
// A stalled output freezes the whole pipeline; in_stall follows it.
`timescale 1ns / 1ps
module voxel_index_coordinate_convert_core #(
    parameter int DIM_MAX = vicc_pkg::DIM_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  vicc_pkg::in_t                        in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output vicc_pkg::out_t                       out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vicc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vicc_pkg::DIM_W-1:0]          cfg_data
);
    import vicc_pkg::*;

    localparam int QW = $clog2(DIM_MAX);
    localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(DIM_MAX);

    logic en;
    logic [DIM_W-1:0] dim_x_reg, dim_y_reg, dim_z_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg <= DIM_W'(1);
            dim_y_reg <= DIM_W'(1);
            dim_z_reg <= DIM_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DIM_X: dim_x_reg <= cfg_data;
                REG_DIM_Y: dim_y_reg <= cfg_data;
                REG_DIM_Z: dim_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Freeze everything while the result is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Front stages: capture, strides, products, mode select
    logic             v0_reg, v1_reg, v2_reg, v3_reg;
    in_t              i0_reg, i1_reg, i2_reg;
    logic [DIM_W-1:0] dx0_reg, dy0_reg, dz0_reg, dx1_reg, dz1_reg, dx2_reg;
    logic             inb0_reg, inb1_reg, inb2_reg;
    logic [STRIDE_W-1:0] stride1_reg, stride2_reg;
    logic [20:0]      cydx1_reg;
    logic [31:0]      count2_reg;
    logic [HANDLE_W-1:0] czs2_reg;
    logic [21:0]      sum2_reg;
    logic [DIM_W-1:0] dx_eff, dy_eff, dz_eff;
    pipe_t            p3_next, p3_reg;

    always_comb
    begin
        dx_eff = (dim_x_reg > DIM_LIM) ? DIM_LIM : dim_x_reg;
        dy_eff = (dim_y_reg > DIM_LIM) ? DIM_LIM : dim_y_reg;
        dz_eff = (dim_z_reg > DIM_LIM) ? DIM_LIM : dim_z_reg;
    end

    // Select per mode and check range
    always_comb
    begin
        p3_next        = '0;
        p3_next.func   = i2_reg.func;
        p3_next.cx     = i2_reg.coord_x;
        p3_next.cy     = i2_reg.coord_y;
        p3_next.cz     = i2_reg.coord_z;
        p3_next.dx     = dx2_reg;
        p3_next.rem    = i2_reg.handle_in - HANDLE_W'(1);
        p3_next.dvs    = stride2_reg;
        if (i2_reg.func)
        begin
            p3_next.ok     = (i2_reg.handle_in != '0) &&
                             (32'(i2_reg.handle_in) <= count2_reg);
            p3_next.handle = i2_reg.handle_in;
        end
        else
        begin
            p3_next.ok     = inb2_reg;
            p3_next.handle = HANDLE_W'(sum2_reg) + czs2_reg + HANDLE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i0_reg      <= in_data;
            dx0_reg     <= dx_eff;
            dy0_reg     <= dy_eff;
            dz0_reg     <= dz_eff;
            inb0_reg    <= (DIM_W'(in_data.coord_x) < dx_eff) &&
                           (DIM_W'(in_data.coord_y) < dy_eff) &&
                           (DIM_W'(in_data.coord_z) < dz_eff);
            i1_reg      <= i0_reg;
            dx1_reg     <= dx0_reg;
            dz1_reg     <= dz0_reg;
            inb1_reg    <= inb0_reg;
            stride1_reg <= STRIDE_W'(dx0_reg) * STRIDE_W'(dy0_reg);
            cydx1_reg   <= 21'(i0_reg.coord_y) * 21'(dx0_reg);
            i2_reg      <= i1_reg;
            dx2_reg     <= dx1_reg;
            inb2_reg    <= inb1_reg;
            stride2_reg <= stride1_reg;
            count2_reg  <= 32'(stride1_reg) * 32'(dz1_reg);
            czs2_reg    <= HANDLE_W'(32'(i1_reg.coord_z) * 32'(stride1_reg));
            sum2_reg    <= 22'(i1_reg.coord_x) + 22'(cydx1_reg);
            p3_reg      <= p3_next;
        end
    end

    // Chain for z = index / plane stride
    logic  zv [QW+1];
    pipe_t zd [QW+1];
    assign zv[0] = v3_reg;
    assign zd[0] = p3_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_zchain
        vicc_div_cell #(.SHIFT(QW - 1 - k)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .vld_in (zv[k]),
            .d_in   (zd[k]),
            .vld_out(zv[k+1]),
            .d_out  (zd[k+1])
        );
    end

    // Hand the plane remainder to the row chain
    logic  vt_reg;
    pipe_t pt_reg;
    pipe_t pt_next;
    always_comb
    begin
        pt_next     = zd[QW];
        pt_next.zq  = zd[QW].quo;
        pt_next.dvs = STRIDE_W'(zd[QW].dx);
        pt_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vt_reg <= 1'b0;
        else if (en)
            vt_reg <= zv[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pt_reg <= pt_next;
    end

    // Chain for y = plane / dx, x = remainder
    logic  yv [QW+1];
    pipe_t yd [QW+1];
    assign yv[0] = vt_reg;
    assign yd[0] = pt_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_ychain
        vicc_div_cell #(.SHIFT(QW - 1 - k)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .vld_in (yv[k]),
            .d_in   (yd[k]),
            .vld_out(yv[k+1]),
            .d_out  (yd[k+1])
        );
    end

    // Form the result fields
    logic  vm_reg;
    out_t  rm_next, rm_reg;
    pipe_t pf;
    always_comb
    begin
        pf      = yd[QW];
        rm_next = '0;
        if (pf.ok)
        begin
            rm_next.valid_res  = 1'b1;
            rm_next.handle_out = pf.handle;
            if (pf.func)
            begin
                rm_next.x_out = pf.rem[COORD_W-1:0];
                rm_next.y_out = pf.quo;
                rm_next.z_out = pf.zq;
            end
            else
            begin
                rm_next.x_out = pf.cx;
                rm_next.y_out = pf.cy;
                rm_next.z_out = pf.cz;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else if (en)
            vm_reg <= yv[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rm_reg <= rm_next;
    end

    // Hash and output register
    vicc_hash u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vld_in (vm_reg),
        .res_in (rm_reg),
        .vld_out(out_valid),
        .res_out(out_data)
    );
endmodule

// File: dv/voxel_index_coordinate_convert_core_tb.sv
// Testbench: voxel index/coordinate converter checked against a built-in grid predictor.
`timescale 1ns / 1ps
module voxel_index_coordinate_convert_core_tb;
    import vicc_pkg::*;

    localparam int LATENCY   = 2 * 10 + 10;
    localparam int MAX_CYCLE = 400000;
    localparam int IN_BITS   = $bits(in_t);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        in_t  stim;
        out_t want;
        bit   typed;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t  in_data;
    logic out_valid;
    logic out_stall;
    out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0] cfg_data;

    // grid registers as the block should hold them
    logic [DIM_W-1:0] grid_dx, grid_dy, grid_dz;
    out_t    cell_q[$];
    int      err_cnt;
    int      cycle_cnt;
    int      send_gap_pct;
    int      recv_stall_pct;
    dir_row_t dir_tbl[10];

    voxel_index_coordinate_convert_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [31:0] eff_dim(input logic [DIM_W-1:0] d);
        return (d > DIM_MAX_DEF) ? DIM_MAX_DEF : 32'(d);
    endfunction

    function automatic logic [31:0] cell_hash(input logic [31:0] x, y, z);
        logic [31:0] h;
        h = (x * HASH_PX) ^ (y * HASH_PY) ^ (z * HASH_PZ);
        h = h ^ (h >> 16);
        h = h * HASH_M1;
        h = h ^ (h >> 15);
        h = h * HASH_M2;
        h = h ^ (h >> 16);
        return h;
    endfunction

    // Convert one request under the current grid dimensions
    function automatic out_t convert_cell(input in_t d);
        logic [63:0] dx, dy, dz, sz, cnt, idx, pl, hnd;
        logic [31:0] x, y, z;
        logic        ok;
        out_t        r;
        dx = eff_dim(grid_dx);
        dy = eff_dim(grid_dy);
        dz = eff_dim(grid_dz);
        sz = dx * dy;
        cnt = sz * dz;
        ok = 1'b0;
        hnd = 0;
        x = 0;
        y = 0;
        z = 0;
        if (d.func == 1'b0)
        begin
            if (d.coord_x < dx && d.coord_y < dy && d.coord_z < dz)
            begin
                ok = 1'b1;
                x = d.coord_x;
                y = d.coord_y;
                z = d.coord_z;
                hnd = d.coord_x + d.coord_y * dx + d.coord_z * sz + 1;
            end
        end
        else if (d.handle_in != 0 && d.handle_in <= cnt && dx != 0 && sz != 0)
        begin
            ok = 1'b1;
            hnd = d.handle_in;
            idx = hnd - 1;
            pl = idx % sz;
            z = 32'(idx / sz);
            y = 32'(pl / dx);
            x = 32'(pl % dx);
        end
        r.valid_res = ok;
        r.handle_out = hnd[HANDLE_W-1:0];
        r.x_out = x[COORD_W-1:0];
        r.y_out = y[COORD_W-1:0];
        r.z_out = z[COORD_W-1:0];
        r.cell_value = ok ? VALUE_W'(1 + (cell_hash(x, y, z) & 3)) : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got, want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    // Drive one request from a falling edge; hold it until the transaction completes
    task automatic send_req(input in_t d, input bit typed, input out_t want);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            in_data <= in_t'(IN_BITS'({$urandom, $urandom}));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        do
            @(posedge clk);
        while (in_stall);
        cell_q.push_back(typed ? want : convert_cell(d));
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_DIM_X: grid_dx = val;
            REG_DIM_Y: grid_dy = val;
            REG_DIM_Z: grid_dz = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop the input and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        wait (cell_q.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
        @(negedge clk);
    endtask

    // Random request, mostly inside the grid
    function automatic in_t rand_req();
        in_t         d;
        logic [31:0] ex, ey, ez;
        logic [63:0] cnt;
        int          pick;
        ex = eff_dim(grid_dx);
        ey = eff_dim(grid_dy);
        ez = eff_dim(grid_dz);
        cnt = 64'(ex) * ey * ez;
        d = in_t'(IN_BITS'({$urandom, $urandom}));
        pick = $urandom_range(99);
        if (d.func == 1'b0)
        begin
            if (pick < 80 && ex != 0 && ey != 0 && ez != 0)
            begin
                d.coord_x = COORD_W'($urandom_range(ex - 1));
                d.coord_y = COORD_W'($urandom_range(ey - 1));
                d.coord_z = COORD_W'($urandom_range(ez - 1));
            end
        end
        else if (pick < 80 && cnt != 0)
            d.handle_in = HANDLE_W'($urandom_range(32'(cnt), 1));
        else if (pick < 90)
            d.handle_in = HANDLE_W'(cnt + $urandom_range(3));
        return d;
    endfunction

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cell_q.size() == 0)
            begin
                report_mismatch("unexpected result", 32'd1, 32'd0);
            end
            else
            begin
                want = cell_q.pop_front();
                if (out_data.valid_res !== want.valid_res)
                    report_mismatch("valid_res", out_data.valid_res, want.valid_res);
                if (out_data.handle_out !== want.handle_out)
                    report_mismatch("handle_out", out_data.handle_out, want.handle_out);
                if (out_data.x_out !== want.x_out)
                    report_mismatch("x_out", out_data.x_out, want.x_out);
                if (out_data.y_out !== want.y_out)
                    report_mismatch("y_out", out_data.y_out, want.y_out);
                if (out_data.z_out !== want.z_out)
                    report_mismatch("z_out", out_data.z_out, want.z_out);
                if (out_data.cell_value !== want.cell_value)
                    report_mismatch("cell_value", out_data.cell_value, want.cell_value);
            end
        end
    end

    // Stall the output at random
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLE)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [DIM_W-1:0] dims[6][3];
        logic [31:0]      ex, ey, ez;
        in_t              d;
        out_t             nil;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        err_cnt = 0;
        cycle_cnt = 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        grid_dx = 1;
        grid_dy = 1;
        grid_dz = 1;
        nil = '0;

        // After reset the grid is one cell
        dir_tbl[0] = '{in_t'({1'b0, 10'd0, 10'd0, 10'd0, 31'h7FFFFFFF}),
                       out_t'({1'b1, 31'd1, 10'd0, 10'd0, 10'd0, 3'd1}), 1'b1};
        dir_tbl[1] = '{in_t'({1'b0, 10'd1, 10'd0, 10'd0, 31'd0}), nil, 1'b1};
        dir_tbl[2] = '{in_t'({1'b0, 10'd0, 10'd1, 10'd0, 31'd0}), nil, 1'b1};
        dir_tbl[3] = '{in_t'({1'b0, 10'd0, 10'd0, 10'd1, 31'd0}), nil, 1'b1};
        dir_tbl[4] = '{in_t'({1'b0, 10'd1023, 10'd1023, 10'd1023, 31'd0}), nil, 1'b1};
        dir_tbl[5] = '{in_t'({1'b1, 10'd1023, 10'd1023, 10'd1023, 31'd1}),
                       out_t'({1'b1, 31'd1, 10'd0, 10'd0, 10'd0, 3'd1}), 1'b1};
        dir_tbl[6] = '{in_t'({1'b1, 10'd0, 10'd0, 10'd0, 31'd0}), nil, 1'b1};
        dir_tbl[7] = '{in_t'({1'b1, 10'd0, 10'd0, 10'd0, 31'd2}), nil, 1'b1};
        dir_tbl[8] = '{in_t'({1'b1, 10'd0, 10'd0, 10'd0, 31'h7FFFFFFF}), nil, 1'b1};
        dir_tbl[9] = '{in_t'({1'b1, 10'd5, 10'd0, 10'd0, 31'h40000000}), nil, 1'b0};

        // Grid settings: largest, empty, oversized, mixed
        dims[0] = '{11'd1024, 11'd1024, 11'd1024};
        dims[1] = '{11'd0, 11'd7, 11'd7};
        dims[2] = '{11'd2047, 11'd3, 11'd2};
        dims[3] = '{11'd5, 11'd3, 11'd1025};
        dims[4] = '{11'd1, 11'd1024, 11'd9};
        dims[5] = '{11'd13, 11'd0, 11'd1};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tbl[i])
            send_req(dir_tbl[i].stim, dir_tbl[i].typed, dir_tbl[i].want);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
            write_reg(REG_DIM_X, dims[ph][0]);
            write_reg(REG_DIM_Y, dims[ph][1]);
            write_reg(REG_DIM_Z, dims[ph][2]);
            // index past the last register must be ignored
            write_reg(REG_UNUSED, DIM_W'($urandom));
            case (ph % 4)
                1: send_gap_pct = 50;
                2: recv_stall_pct = 50;
                3:
                begin
                    send_gap_pct = 10;
                    recv_stall_pct = 10;
                end
                default: ;
            endcase

            // Corners of this grid
            ex = eff_dim(grid_dx);
            ey = eff_dim(grid_dy);
            ez = eff_dim(grid_dz);
            d = '0;
            d.coord_x = COORD_W'(ex - 1);
            d.coord_y = COORD_W'(ey - 1);
            d.coord_z = COORD_W'(ez - 1);
            send_req(d, 1'b0, nil);
            d.func = 1'b1;
            d.handle_in = HANDLE_W'(64'(ex) * ey * ez);
            send_req(d, 1'b0, nil);
            d.handle_in = d.handle_in + 1;
            send_req(d, 1'b0, nil);

            for (int n = 0; n < 145; n++)
            begin
                // Let the pipeline empty once mid-phase
                if (ph == 1 && n == 60)
                begin
                    in_valid <= 1'b0;
                    wait (cell_q.size() == 0);
                    @(negedge clk);
                end
                send_req(rand_req(), 1'b0, nil);
            end
            drain();
        end

        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: voxel_index_coordinate_convert_core.f
rtl/vicc_pkg.sv
rtl/vicc_div_cell.sv
rtl/vicc_hash.sv
rtl/voxel_index_coordinate_convert_core.sv
dv/voxel_index_coordinate_convert_core_tb.sv
